FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked on every clock edge outside reset.
`define E2Q_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("e2q check failed");
// Checked on every clock edge, reset included.
`define E2Q_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("e2q check failed");
`endif

FILE: src/e2q_pkg.sv
// Package with widths and constants of the Euler angle to quaternion converter.
`default_nettype none
package e2q_pkg;
  localparam int IN_W      = 17;
  localparam int OUT_W     = 16;
  localparam int ITERS     = 20;
  localparam int XY_W      = 33;
  localparam int Z_W       = 31;
  localparam int P_W       = 34;
  localparam int SUM_W     = 36;
  localparam int WORK_BITS = 30;
  localparam int OUT_FRAC  = 14;
  localparam int ANG_SHIFT = 12;
  localparam int OUT_SHIFT = WORK_BITS - OUT_FRAC;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [Z_W-1:0] FULL_TURN  = 31'sd377487360;
  localparam logic signed [Z_W-1:0] HALF_TURN  = 31'sd188743680;
  localparam logic signed [Z_W-1:0] QUARTER    = 31'sd94371840;
  localparam logic signed [SUM_W-1:0] OUT_LIM  = 36'sd16384;

  localparam logic signed [Z_W-1:0] ATAN [ITERS] = '{
    31'sd47185920, 31'sd27855475, 31'sd14718068, 31'sd7471121, 31'sd3750058,
    31'sd1876857,  31'sd938658,   31'sd469357,   31'sd234682,  31'sd117342,
    31'sd58671,    31'sd29335,    31'sd14668,    31'sd7334,    31'sd3667,
    31'sd1833,     31'sd917,      31'sd458,      31'sd229,     31'sd115
  };
endpackage
`default_nettype wire

FILE: src/e2q_cordic.sv
// One CORDIC lane: half-angle range reduction, iterations and sign fix.
`default_nettype none
module e2q_cordic (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [e2q_pkg::IN_W-1:0]      ang,
  output logic signed [e2q_pkg::XY_W-1:0]           sin_q,
  output logic signed [e2q_pkg::XY_W-1:0]           cos_q
);
  logic signed [e2q_pkg::Z_W-1:0]  z_half;
  logic signed [e2q_pkg::Z_W-1:0]  z_wrap;
  logic signed [e2q_pkg::Z_W-1:0]  z_fold;
  logic                            neg_fold;
  logic signed [e2q_pkg::XY_W-1:0] xs [e2q_pkg::ITERS+1];
  logic signed [e2q_pkg::XY_W-1:0] ys [e2q_pkg::ITERS+1];
  logic signed [e2q_pkg::Z_W-1:0]  zs [e2q_pkg::ITERS+1];
  logic                            ns [e2q_pkg::ITERS+1];

  always_comb begin
    z_half = {{(e2q_pkg::Z_W-e2q_pkg::IN_W-e2q_pkg::ANG_SHIFT){ang[e2q_pkg::IN_W-1]}},
              ang, {e2q_pkg::ANG_SHIFT{1'b0}}};
    if (z_half > e2q_pkg::HALF_TURN) begin
      z_wrap = z_half - e2q_pkg::FULL_TURN;
    end else if (z_half <= -e2q_pkg::HALF_TURN) begin
      z_wrap = z_half + e2q_pkg::FULL_TURN;
    end else begin
      z_wrap = z_half;
    end
    if (z_wrap > e2q_pkg::QUARTER) begin
      z_fold   = z_wrap - e2q_pkg::HALF_TURN;
      neg_fold = 1'b1;
    end else if (z_wrap < -e2q_pkg::QUARTER) begin
      z_fold   = z_wrap + e2q_pkg::HALF_TURN;
      neg_fold = 1'b1;
    end else begin
      z_fold   = z_wrap;
      neg_fold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= e2q_pkg::CORDIC_X0;
      ys[0] <= '0;
      zs[0] <= z_fold;
      ns[0] <= neg_fold;
    end
  end

  for (genvar i = 0; i < e2q_pkg::ITERS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - e2q_pkg::ATAN[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + e2q_pkg::ATAN[i];
        end
        ns[i+1] <= ns[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= ns[e2q_pkg::ITERS] ? -xs[e2q_pkg::ITERS] : xs[e2q_pkg::ITERS];
      sin_q <= ns[e2q_pkg::ITERS] ? -ys[e2q_pkg::ITERS] : ys[e2q_pkg::ITERS];
    end
  end
endmodule
`default_nettype wire

FILE: src/e2q_mult.sv
// Product pipeline: pair products, triple products, sums, rounding and clamping.
`default_nettype none
module e2q_mult (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [e2q_pkg::XY_W-1:0]   sh,
  input  wire logic signed [e2q_pkg::XY_W-1:0]   ch,
  input  wire logic signed [e2q_pkg::XY_W-1:0]   sp,
  input  wire logic signed [e2q_pkg::XY_W-1:0]   cp,
  input  wire logic signed [e2q_pkg::XY_W-1:0]   sb,
  input  wire logic signed [e2q_pkg::XY_W-1:0]   cb,
  output logic signed [e2q_pkg::OUT_W-1:0]       quat_w,
  output logic signed [e2q_pkg::OUT_W-1:0]       quat_x,
  output logic signed [e2q_pkg::OUT_W-1:0]       quat_y,
  output logic signed [e2q_pkg::OUT_W-1:0]       quat_z
);
  localparam int PA_W = 2 * e2q_pkg::XY_W;
  localparam int PB_W = e2q_pkg::P_W + e2q_pkg::XY_W;
  localparam logic signed [PA_W-1:0] RND_A = PA_W'(1) <<< (e2q_pkg::WORK_BITS - 1);
  localparam logic signed [PB_W-1:0] RND_B = PB_W'(1) <<< (e2q_pkg::WORK_BITS - 1);
  localparam logic signed [e2q_pkg::SUM_W-1:0] RND_O =
    e2q_pkg::SUM_W'(1) <<< (e2q_pkg::OUT_SHIFT - 1);

  // Pair products: ch*cp, sh*sp, ch*sp, sh*cp, with sines and cosines of bank delayed.
  logic signed [PA_W-1:0] pa [4];
  logic signed [e2q_pkg::XY_W-1:0] sb1, cb1, sb2, cb2;
  logic signed [e2q_pkg::P_W-1:0] qa [4];
  // Triple products: ccc, sss, csc, scs, scc, css, ccs, ssc.
  logic signed [PB_W-1:0] pb [8];
  logic signed [e2q_pkg::P_W-1:0] qb [8];
  logic signed [e2q_pkg::SUM_W-1:0] sums [4];
  logic signed [e2q_pkg::SUM_W-1:0] rnd [4];
  logic signed [e2q_pkg::OUT_W-1:0] res [4];

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= ch * cp;
      pa[1] <= sh * sp;
      pa[2] <= ch * sp;
      pa[3] <= sh * cp;
      sb1 <= sb;
      cb1 <= cb;
      for (int k = 0; k < 4; k++) begin
        qa[k] <= e2q_pkg::P_W'((pa[k] + RND_A) >>> e2q_pkg::WORK_BITS);
      end
      sb2 <= sb1;
      cb2 <= cb1;
      pb[0] <= qa[0] * cb2;
      pb[1] <= qa[1] * sb2;
      pb[2] <= qa[2] * cb2;
      pb[3] <= qa[3] * sb2;
      pb[4] <= qa[3] * cb2;
      pb[5] <= qa[2] * sb2;
      pb[6] <= qa[0] * sb2;
      pb[7] <= qa[1] * cb2;
      for (int k = 0; k < 8; k++) begin
        qb[k] <= e2q_pkg::P_W'((pb[k] + RND_B) >>> e2q_pkg::WORK_BITS);
      end
      quat_w <= res[0];
      quat_x <= res[1];
      quat_y <= res[2];
      quat_z <= res[3];
    end
  end

  always_comb begin
    sums[0] = e2q_pkg::SUM_W'(qb[0]) + e2q_pkg::SUM_W'(qb[1]);
    sums[1] = e2q_pkg::SUM_W'(qb[2]) + e2q_pkg::SUM_W'(qb[3]);
    sums[2] = e2q_pkg::SUM_W'(qb[4]) - e2q_pkg::SUM_W'(qb[5]);
    sums[3] = e2q_pkg::SUM_W'(qb[6]) - e2q_pkg::SUM_W'(qb[7]);
    for (int k = 0; k < 4; k++) begin
      rnd[k] = (sums[k] + RND_O) >>> e2q_pkg::OUT_SHIFT;
      if (rnd[k] > e2q_pkg::OUT_LIM) begin
        res[k] = e2q_pkg::OUT_W'(e2q_pkg::OUT_LIM);
      end else if (rnd[k] < -e2q_pkg::OUT_LIM) begin
        res[k] = e2q_pkg::OUT_W'(-e2q_pkg::OUT_LIM);
      end else begin
        res[k] = rnd[k][e2q_pkg::OUT_W-1:0];
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/euler_to_quaternion.sv
// Top level of the heading, pitch and bank to unit quaternion converter.
// Usage:
// The input channel carries one word per handshake: heading, pitch and bank in
// signed degrees with 1/128-degree steps. A word is taken at a rising edge where
// in_valid is high and in_stall is low.
// The output channel carries quat_w, quat_x, quat_y and quat_z in signed Q1.14,
// where 16384 means 1.0, under out_valid and out_stall with the same rule.
// Throughput is one word per cycle unless a result waits on out_stall. The pipe
// is 27 register stages deep: a result shows on the outputs from the last stage,
// and can be taken at the next edge at the earliest. The depth is set by the three
// parallel CORDIC lanes (one range-reduction stage, twenty iteration stages, one
// sign stage) and the five stages of products, rounding and saturation.
// The whole pipeline advances as one unit. While a result waits on a high
// out_stall, every stage holds and in_stall is raised, so nothing is lost or
// repeated; empty stages do not hold the pipe back since a stall only occurs
// when the output register holds a valid word.
// A synchronous reset clears all valid bits; data registers keep their
// contents, which are never shown without a valid bit.
`default_nettype none
`include "assert_macros.svh"
module euler_to_quaternion (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [e2q_pkg::IN_W-1:0]     heading,
  input  wire logic signed [e2q_pkg::IN_W-1:0]     pitch,
  input  wire logic signed [e2q_pkg::IN_W-1:0]     bank,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [e2q_pkg::OUT_W-1:0]         quat_w,
  output logic signed [e2q_pkg::OUT_W-1:0]         quat_x,
  output logic signed [e2q_pkg::OUT_W-1:0]         quat_y,
  output logic signed [e2q_pkg::OUT_W-1:0]         quat_z
);
  // Two CORDIC stages beyond the iterations plus five product stages.
  localparam int LAT = e2q_pkg::ITERS + 7;

  logic en;
  logic [LAT-1:0] vld;
  logic signed [e2q_pkg::XY_W-1:0] sh, ch, sp, cp, sb, cb;

  // The pipe moves unless the output holds a word that is not being taken.
  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  e2q_cordic u_head (.clk(clk), .en(en), .ang(heading), .sin_q(sh), .cos_q(ch));
  e2q_cordic u_pitch (.clk(clk), .en(en), .ang(pitch), .sin_q(sp), .cos_q(cp));
  e2q_cordic u_bank (.clk(clk), .en(en), .ang(bank), .sin_q(sb), .cos_q(cb));

  e2q_mult u_mult (
    .clk(clk), .en(en),
    .sh(sh), .ch(ch), .sp(sp), .cp(cp), .sb(sb), .cb(cb),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
  );

  `E2Q_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid)
  `E2Q_ASSERT(a_stall_holds, (out_valid && out_stall) |=> $stable({quat_w, quat_z}))
  `E2Q_ASSERT(a_w_range, out_valid |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384))
  `E2Q_ASSERT(a_accept_moves, (in_valid && !in_stall) |=> vld[0])
endmodule
`default_nettype wire

FILE: dv/euler_to_quaternion_test.sv
// Self-checking testbench for the Euler angle to quaternion converter.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion_test;

  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS = 450;

  typedef struct packed {
    logic signed [e2q_pkg::OUT_W-1:0] w;
    logic signed [e2q_pkg::OUT_W-1:0] x;
    logic signed [e2q_pkg::OUT_W-1:0] y;
    logic signed [e2q_pkg::OUT_W-1:0] z;
  } quat_t;

  typedef struct {
    int   hdg;
    int   pit;
    int   bnk;
    bit   known;
    quat_t q;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [e2q_pkg::IN_W-1:0] heading = '0;
  logic signed [e2q_pkg::IN_W-1:0] pitch = '0;
  logic signed [e2q_pkg::IN_W-1:0] bank = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [e2q_pkg::OUT_W-1:0] quat_w, quat_x, quat_y, quat_z;

  quat_t pending_quats[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit stimulus_done = 1'b0;

  // The clock runs with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  euler_to_quaternion i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .heading(heading), .pitch(pitch), .bank(bank),
    .out_valid(out_valid), .out_stall(out_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
  );

  // Floor shift for signed 64-bit values; the >>> operator already floors.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Rounded Q30 product of two Q30 operands.
  function automatic longint q30_mul(longint a, longint b);
    return floor_shift(a * b + (64'sd1 <<< (e2q_pkg::WORK_BITS - 1)), e2q_pkg::WORK_BITS);
  endfunction

  // Sine and cosine of half of an input angle, both in Q30. The half angle is
  // taken in 2^-20 degree units, wrapped into (-180, 180], folded into the
  // right half plane, and then run through twenty CORDIC rotations.
  task automatic half_angle_sincos(input logic signed [e2q_pkg::IN_W-1:0] ang,
                                   output longint sin_q, output longint cos_q);
    longint full_turn, half_turn, quarter;
    longint z, x, y, dx, dy;
    bit flip;
    full_turn = 64'sd360 <<< 20;
    half_turn = 64'sd180 <<< 20;
    quarter = 64'sd90 <<< 20;
    z = (longint'(ang) * (64'sd1 <<< e2q_pkg::ANG_SHIFT)) % full_turn;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z < 0) z += full_turn;
    if (z > half_turn) z -= full_turn;
    if (z > quarter) begin
      z -= half_turn;
      flip = 1'b1;
    end else if (z < -quarter) begin
      z += half_turn;
      flip = 1'b1;
    end
    for (int i = 0; i < e2q_pkg::ITERS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(e2q_pkg::ATAN[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(e2q_pkg::ATAN[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    sin_q = y;
    cos_q = x;
  endtask

  // Round a Q30 sum to the output fraction and clamp it to plus or minus one.
  function automatic logic signed [e2q_pkg::OUT_W-1:0] round_clamp(longint v);
    longint r;
    longint lim;
    lim = 64'sd1 <<< e2q_pkg::OUT_FRAC;
    r = floor_shift(v + (64'sd1 <<< (e2q_pkg::OUT_SHIFT - 1)), e2q_pkg::OUT_SHIFT);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[e2q_pkg::OUT_W-1:0];
  endfunction

  // Quaternion of one heading, pitch and bank triple. Triple products are
  // rounded pairwise in the order the formulas are written.
  task automatic predict_quat(input logic signed [e2q_pkg::IN_W-1:0] h,
                              input logic signed [e2q_pkg::IN_W-1:0] p,
                              input logic signed [e2q_pkg::IN_W-1:0] b,
                              output quat_t q);
    longint sh, ch, sp, cp, sb, cb;
    half_angle_sincos(h, sh, ch);
    half_angle_sincos(p, sp, cp);
    half_angle_sincos(b, sb, cb);
    q.w = round_clamp(q30_mul(q30_mul(ch, cp), cb) + q30_mul(q30_mul(sh, sp), sb));
    q.x = round_clamp(q30_mul(q30_mul(ch, sp), cb) + q30_mul(q30_mul(sh, cp), sb));
    q.y = round_clamp(q30_mul(q30_mul(sh, cp), cb) - q30_mul(q30_mul(ch, sp), sb));
    q.z = round_clamp(q30_mul(q30_mul(ch, cp), sb) - q30_mul(q30_mul(sh, sp), cb));
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Mostly short gaps, now and then a long one, often none at all.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // The directed table. Only the all-zero row carries its result; full turns,
  // half turns, quarter turns and the ends of the bit range go to the predictor.
  stim_row_t directed_rows[$];

  function automatic stim_row_t row(int h, int p, int b, bit k, quat_t q);
    stim_row_t r;
    r.hdg = h;
    r.pit = p;
    r.bnk = b;
    r.known = k;
    r.q = q;
    return r;
  endfunction

  initial begin
    quat_t unit_q, none_q;
    unit_q = '{w: 16'sd16384, x: 16'sd0, y: 16'sd0, z: 16'sd0};
    none_q = '0;
    directed_rows.push_back(row(0, 0, 0, 1'b1, unit_q));
    directed_rows.push_back(row(46080, 0, 0, 1'b0, none_q));
    directed_rows.push_back(row(-46080, 0, 0, 1'b0, none_q));
    directed_rows.push_back(row(0, 46080, 0, 1'b0, none_q));
    directed_rows.push_back(row(0, 0, -46080, 1'b0, none_q));
    directed_rows.push_back(row(23040, 0, 0, 1'b0, none_q));
    directed_rows.push_back(row(0, 23040, 0, 1'b0, none_q));
    directed_rows.push_back(row(0, 0, 23040, 1'b0, none_q));
    directed_rows.push_back(row(11520, 11520, 11520, 1'b0, none_q));
    directed_rows.push_back(row(-11520, -11520, -11520, 1'b0, none_q));
    directed_rows.push_back(row(23040, 23040, 23040, 1'b0, none_q));
    directed_rows.push_back(row(46080, 46080, 46080, 1'b0, none_q));
    directed_rows.push_back(row(65535, -65536, 1, 1'b0, none_q));
    directed_rows.push_back(row(-65536, 65535, -1, 1'b0, none_q));
    directed_rows.push_back(row(-1, -1, -1, 1'b0, none_q));
    directed_rows.push_back(row(1, 1, 1, 1'b0, none_q));
    directed_rows.push_back(row(5760, -5760, 17280, 1'b0, none_q));
    directed_rows.push_back(row(46079, -46079, 23041, 1'b0, none_q));
    directed_rows.push_back(row(43690, 21845, -21846, 1'b0, none_q));
  end

  // Sender: a word is held until the handshake completes, then replaced or
  // dropped at the same edge, so valid gets one assignment per step.
  task automatic send_word(input logic signed [e2q_pkg::IN_W-1:0] h,
                           input logic signed [e2q_pkg::IN_W-1:0] p,
                           input logic signed [e2q_pkg::IN_W-1:0] b,
                           input bit known, input quat_t known_q);
    quat_t q;
    int gap;
    predict_quat(h, p, b, q);
    if (known && q != known_q)
      report_mismatch($sformatf("predictor disagrees with table row %0d %0d %0d",
                                h, p, b));
    gap = gap_length();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    heading <= h;
    pitch <= p;
    bank <= b;
    pending_quats.push_back(known ? known_q : q);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic signed [e2q_pkg::IN_W-1:0] h, p, b;
    int roll;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i])
      send_word(e2q_pkg::IN_W'(directed_rows[i].hdg),
                e2q_pkg::IN_W'(directed_rows[i].pit),
                e2q_pkg::IN_W'(directed_rows[i].bnk),
                directed_rows[i].known, directed_rows[i].q);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        // Angles within plus or minus one full turn.
        h = e2q_pkg::IN_W'(int'($urandom_range(0, 92160)) - 46080);
        p = e2q_pkg::IN_W'(int'($urandom_range(0, 92160)) - 46080);
        b = e2q_pkg::IN_W'(int'($urandom_range(0, 92160)) - 46080);
      end else begin
        // Any bit pattern, so every input bit toggles.
        h = e2q_pkg::IN_W'($urandom());
        p = e2q_pkg::IN_W'($urandom());
        b = e2q_pkg::IN_W'($urandom());
      end
      send_word(h, p, b, 1'b0, '0);
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver stall, random with the same gap shape.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = gap_length();
      out_stall <= (gap != 0);
      repeat (gap == 0 ? $urandom_range(1, 20) : gap) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    quat_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{w: quat_w, x: quat_x, y: quat_y, z: quat_z};
      if (pending_quats.size() == 0) begin
        report_mismatch("result word with no prediction waiting");
      end else begin
        want = pending_quats.pop_front();
        if (got.w !== want.w)
          report_mismatch($sformatf("quat_w got %0d want %0d", got.w, want.w));
        if (got.x !== want.x)
          report_mismatch($sformatf("quat_x got %0d want %0d", got.x, want.x));
        if (got.y !== want.y)
          report_mismatch($sformatf("quat_y got %0d want %0d", got.y, want.y));
        if (got.z !== want.z)
          report_mismatch($sformatf("quat_z got %0d want %0d", got.z, want.z));
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // End of run: drain, keep watching for stray results, then give the verdict.
  initial begin
    @(posedge clk);
    while (!(stimulus_done && pending_quats.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("euler_to_quaternion test failed");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (mismatch_count == 0)
        $display("euler_to_quaternion test passed");
      else
        $display("euler_to_quaternion test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+src
src/e2q_pkg.sv
src/e2q_cordic.sv
src/e2q_mult.sv
src/euler_to_quaternion.sv
dv/euler_to_quaternion_test.sv
